@@ design/cmbi_pkg.sv @@
// Shared types and constants for the cartridge mapper bank and IRQ unit.
`default_nettype none
package cmbi_pkg;

	// Command codes
	localparam logic [2:0] CMD_WRITE  = 3'd0;
	localparam logic [2:0] CMD_TICK   = 3'd1;
	localparam logic [2:0] CMD_XL_PRG = 3'd2;
	localparam logic [2:0] CMD_XL_PAT = 3'd3;
	localparam logic [2:0] CMD_XL_NT  = 3'd4;

	// Register addresses
	localparam logic [15:0] ADDR_PRG0 = 16'h8000;
	localparam logic [15:0] ADDR_PRG1 = 16'h8001;
	localparam logic [15:0] ADDR_PRG2 = 16'h9000;
	localparam logic [15:0] ADDR_PAT0 = 16'hA000;
	localparam logic [15:0] ADDR_PAT1 = 16'hA001;
	localparam logic [15:0] ADDR_PAT2 = 16'hB000;
	localparam logic [15:0] ADDR_PAT3 = 16'hB001;
	localparam logic [15:0] ADDR_PAT4 = 16'hC000;
	localparam logic [15:0] ADDR_PAT5 = 16'hC001;
	localparam logic [15:0] ADDR_PAT6 = 16'hD000;
	localparam logic [15:0] ADDR_PAT7 = 16'hD001;
	localparam logic [15:0] ADDR_MIRROR = 16'hE000;
	localparam logic [15:0] ADDR_IRQ_LATCH = 16'hE001;
	localparam logic [15:0] ADDR_IRQ_CTRL = 16'hF000;
	localparam logic [15:0] ADDR_IRQ_ACK = 16'hF001;

	// Program windows (address bits 15..13)
	localparam logic [2:0] PRG_WIN_0 = 3'd4;
	localparam logic [2:0] PRG_WIN_1 = 3'd5;
	localparam logic [2:0] PRG_WIN_2 = 3'd6;
	localparam logic [2:0] PRG_WIN_FIXED = 3'd7;
	localparam logic [7:0] PRG_FIXED_BANK = 8'hFF;

	// Mirroring modes
	localparam logic [1:0] MIR_VERTICAL = 2'd0;
	localparam logic [1:0] MIR_HORIZONTAL = 2'd1;
	localparam logic [1:0] MIR_SCREEN_A = 2'd2;
	localparam logic [1:0] MIR_SCREEN_B = 2'd3;

	// IRQ counter constants
	localparam logic signed [9:0] PRESCALE_RELOAD = 10'sd341;
	localparam logic signed [9:0] PRESCALE_STEP = 10'sd3;
	localparam logic [7:0] IRQ_COUNT_MAX = 8'hFF;

	localparam int MAP_W = 21;

	// Decoded operation of the item being executed
	typedef struct packed {
		logic wr;
		logic tick;
		logic xl_prg;
		logic xl_pat;
		logic xl_nt;
	} cmbi_op_t;

endpackage
`default_nettype wire

@@ design/cmbi_banks.sv @@
// Bank and mirroring registers with program, pattern and nametable translation.
`default_nettype none
module cmbi_banks (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire cmbi_pkg::cmbi_op_t     op,
	input  wire logic [15:0]            address,
	input  wire logic [7:0]             write_data,
	output logic [cmbi_pkg::MAP_W-1:0]  mapped
);
	import cmbi_pkg::*;

	logic [7:0] prg_bank_q [3];
	logic [7:0] pat_bank_q [8];
	logic [1:0] mirror_q;
	logic [7:0] prg_sel;
	logic [7:0] pat_sel;
	logic [MAP_W-1:0] prg_addr;
	logic [MAP_W-1:0] pat_addr;
	logic [MAP_W-1:0] nt_addr;

	// Register writes at exact addresses
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 3; i++) prg_bank_q[i] <= '0;
			for (int i = 0; i < 8; i++) pat_bank_q[i] <= '0;
			mirror_q <= MIR_VERTICAL;
		end else if (op.wr) begin
			unique case (address)
				ADDR_PRG0: prg_bank_q[0] <= write_data;
				ADDR_PRG1: prg_bank_q[1] <= write_data;
				ADDR_PRG2: prg_bank_q[2] <= write_data;
				ADDR_PAT0: pat_bank_q[0] <= write_data;
				ADDR_PAT1: pat_bank_q[1] <= write_data;
				ADDR_PAT2: pat_bank_q[2] <= write_data;
				ADDR_PAT3: pat_bank_q[3] <= write_data;
				ADDR_PAT4: pat_bank_q[4] <= write_data;
				ADDR_PAT5: pat_bank_q[5] <= write_data;
				ADDR_PAT6: pat_bank_q[6] <= write_data;
				ADDR_PAT7: pat_bank_q[7] <= write_data;
				ADDR_MIRROR: mirror_q <= write_data[1:0];
				default: ;
			endcase
		end
	end

	// Program window select; lower half of the map selects bank number 0
	always_comb begin
		unique case (address[15:13])
			PRG_WIN_0:     prg_sel = prg_bank_q[0];
			PRG_WIN_1:     prg_sel = prg_bank_q[1];
			PRG_WIN_2:     prg_sel = prg_bank_q[2];
			PRG_WIN_FIXED: prg_sel = PRG_FIXED_BANK;
			default:       prg_sel = '0;
		endcase
	end

	assign prg_addr = {prg_sel, address[12:0]};
	assign pat_sel  = pat_bank_q[address[12:10]];
	assign pat_addr = {3'b000, pat_sel, address[9:0]};

	// Nametable mirroring
	always_comb begin
		unique case (mirror_q)
			MIR_VERTICAL:   nt_addr = {10'd0, address[10], address[9:0]};
			MIR_HORIZONTAL: nt_addr = {10'd0, address[11], address[9:0]};
			MIR_SCREEN_A:   nt_addr = {10'd0, 1'b0, address[9:0]};
			MIR_SCREEN_B:   nt_addr = {10'd0, 1'b1, address[9:0]};
			default:        nt_addr = '0;
		endcase
	end

	// Result select; zero for non-translate items
	always_comb begin
		if (op.xl_prg) begin
			mapped = prg_addr;
		end else if (op.xl_pat) begin
			mapped = pat_addr;
		end else if (op.xl_nt) begin
			mapped = nt_addr;
		end else begin
			mapped = '0;
		end
	end

endmodule
`default_nettype wire

@@ design/cmbi_irq.sv @@
// IRQ latch, control, prescaler and counter; gives the IRQ level after each item.
`default_nettype none
module cmbi_irq (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cmbi_pkg::cmbi_op_t op,
	input  wire logic [15:0]        address,
	input  wire logic [7:0]         write_data,
	output logic                    pending_next
);
	import cmbi_pkg::*;

	logic [7:0]        latch_q;
	logic              cycle_mode_q;
	logic              enabled_q;
	logic              enable_ack_q;
	logic [7:0]        count_q;
	logic signed [9:0] presc_q;
	logic              pending_q;

	logic signed [9:0] presc_dec;
	logic              step;
	logic [7:0]        count_step;
	logic              wrap;

	// Prescaler and step decision for a tick
	assign presc_dec  = presc_q - PRESCALE_STEP;
	assign step       = op.tick && enabled_q && (cycle_mode_q || (presc_dec <= 10'sd0));
	assign wrap       = (count_q == IRQ_COUNT_MAX);
	assign count_step = wrap ? latch_q : count_q + 8'd1;

	// Level seen after this item has taken effect
	always_comb begin
		pending_next = pending_q;
		if (op.wr && (address == ADDR_IRQ_CTRL || address == ADDR_IRQ_ACK)) begin
			pending_next = 1'b0;
		end else if (step && wrap) begin
			pending_next = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latch_q      <= '0;
			cycle_mode_q <= 1'b0;
			enabled_q    <= 1'b0;
			enable_ack_q <= 1'b0;
			count_q      <= '0;
			presc_q      <= '0;
			pending_q    <= 1'b0;
		end else begin
			pending_q <= pending_next;
			if (op.wr) begin
				unique case (address)
					ADDR_IRQ_LATCH: latch_q <= write_data;
					ADDR_IRQ_CTRL: begin
						cycle_mode_q <= write_data[2];
						enabled_q    <= write_data[1];
						enable_ack_q <= write_data[0];
						if (write_data[1]) begin
							count_q <= latch_q;
							presc_q <= PRESCALE_RELOAD;
						end
					end
					ADDR_IRQ_ACK: enabled_q <= enable_ack_q;
					default: ;
				endcase
			end else if (op.tick && enabled_q) begin
				if (!cycle_mode_q) begin
					presc_q <= (presc_dec <= 10'sd0) ? presc_dec + PRESCALE_RELOAD : presc_dec;
				end
				if (step) begin
					count_q <= count_step;
				end
			end
		end
	end

endmodule
`default_nettype wire

@@ design/cartridge_mapper_bank_irq_unit.sv @@
// Top level of the cartridge mapper: input stage, command decode, result register.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one command item: command,
//   address and write_data. Commands are register write, CPU-cycle tick,
//   and program, pattern or nametable address translate.
//   Output channel (out_valid/out_ready) returns one result item for every
//   command: mapped_address (zero for non-translate commands) and irq_line,
//   the IRQ level after the command took effect.
//   Flow: an accepted item is held in the input register and executes once
//   the output register is free, loading its result there; out_valid then rises.
//   Throughput: one item per clock while out_ready is high. Bank registers
//   and the IRQ counter update in the execute cycle; the next item sees
//   them at once. Stall: while out_ready is low and a result waits, one
//   more item is held in the input register; in_ready then drops until the
//   result is taken. Reset: arst_n clears all bank, mirroring and IRQ state
//   and empties both the input stage and the output register.
`default_nettype none
module cartridge_mapper_bank_irq_unit (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          in_valid,
	output logic                               in_ready,
	input  wire logic [2:0]                    command,
	input  wire logic [15:0]                   address,
	input  wire logic [7:0]                    write_data,
	output logic                               out_valid,
	input  wire logic                          out_ready,
	output logic [cmbi_pkg::MAP_W-1:0]         mapped_address,
	output logic                               irq_line
);
	import cmbi_pkg::*;

	logic              valid_s1;
	logic [2:0]        cmd_s1;
	logic [15:0]       addr_s1;
	logic [7:0]        data_s1;
	logic              out_valid_q;
	logic [MAP_W-1:0]  mapped_q;
	logic              irq_q;
	logic              out_free;
	logic              fire;
	cmbi_op_t          op;
	logic [MAP_W-1:0]  mapped;
	logic              pending_next;

	// Handshake: execute when the result register can take the result
	assign out_free = !out_valid_q || out_ready;
	assign fire     = valid_s1 && out_free;
	assign in_ready = !valid_s1 || out_free;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			cmd_s1   <= '0;
			addr_s1  <= '0;
			data_s1  <= '0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
			cmd_s1   <= command;
			addr_s1  <= address;
			data_s1  <= write_data;
		end
	end

	// Command decode, gated by execute
	always_comb begin
		op = '0;
		if (fire) begin
			unique case (cmd_s1)
				CMD_WRITE:  op.wr     = 1'b1;
				CMD_TICK:   op.tick   = 1'b1;
				CMD_XL_PRG: op.xl_prg = 1'b1;
				CMD_XL_PAT: op.xl_pat = 1'b1;
				CMD_XL_NT:  op.xl_nt  = 1'b1;
				default: ;
			endcase
		end
	end

	cmbi_banks u_banks (
		.clk        (clk),
		.arst_n     (arst_n),
		.op         (op),
		.address    (addr_s1),
		.write_data (data_s1),
		.mapped     (mapped)
	);

	cmbi_irq u_irq (
		.clk          (clk),
		.arst_n       (arst_n),
		.op           (op),
		.address      (addr_s1),
		.write_data   (data_s1),
		.pending_next (pending_next)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			mapped_q    <= '0;
			irq_q       <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= fire;
			if (fire) begin
				mapped_q <= mapped;
				irq_q    <= pending_next;
			end
		end
	end

	assign out_valid      = out_valid_q;
	assign mapped_address = mapped_q;
	assign irq_line       = irq_q;

endmodule
`default_nettype wire
